// ===== src/tga_pixel_to_rgba_unit_macros.svh =====
// Assertion macros used by the checker of the pixel decoder.
// Both expect a clock named clk and an active-high reset named rst in scope.
`ifndef TGA_PIXEL_TO_RGBA_UNIT_MACROS_SVH
`define TGA_PIXEL_TO_RGBA_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TGAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TGAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tgap_pkg.sv =====
package tgap_pkg;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 64;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_CORNER    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_IS_24BIT = 3'd4;

  localparam logic [7:0] OPAQUE = 8'hff;

  typedef enum logic [1:0] {
    MODE_GREY    = 2'd0,
    MODE_PALETTE = 2'd1,
    MODE_BGR     = 2'd2,
    MODE_BGRA    = 2'd3
  } pixel_mode_t;

  typedef enum logic {
    OP_PALETTE_WRITE = 1'b0,
    OP_DATA_BYTE     = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [1:0]  origin_corner;
    pixel_mode_t pixel_mode;
    logic        palette_is_24bit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;
    logic        bad_palette;
  } pixel_t;

endpackage

// ===== src/tgap_palette_ram.sv =====
module tgap_palette_ram #(
  parameter int ENTRIES = 256,
  parameter int ADDR_W  = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [23:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [23:0]       rd_data
);

  logic [23:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/tgap_pixel_step.sv =====
module tgap_pixel_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              step,
  input  tgap_pkg::cfg_t    cfg,
  input  tgap_pkg::opcode_t opcode,
  input  logic [7:0]        data_byte,
  input  logic [23:0]       lut_color,
  output logic              emit,
  output tgap_pkg::pixel_t  pixel
);

  import tgap_pkg::*;

  logic [15:0] column;
  logic [15:0] row;
  logic [31:0] row_base;
  logic [1:0]  byte_phase;
  logic [23:0] partial_bytes;
  logic        frame_done;

  logic [15:0] column_next;
  logic [15:0] row_next;
  logic [31:0] row_base_next;
  logic [1:0]  byte_phase_next;
  logic [23:0] partial_bytes_next;
  logic        frame_done_next;

  logic [15:0] w;
  logic [15:0] h;
  logic [31:0] start_base;
  logic        from_top;
  logic        from_right;
  logic        row_end;
  logic        col_end;
  logic        bad;
  logic        last;
  logic [23:0] merged;
  logic [23:0] color;
  logic [7:0]  alpha;

  assign w          = (cfg.frame_width == 16'd0) ? 16'd1 : cfg.frame_width;
  assign h          = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;
  assign from_top   = cfg.origin_corner[1];
  assign from_right = cfg.origin_corner[0];
  assign start_base = 32'(h - 16'd1) * 32'(w);
  assign row_end    = from_right ? (column == 16'd0) : (column == w - 16'd1);
  assign col_end    = from_top ? (row == h - 16'd1) : (row == 16'd0);

  always_comb begin
    unique case (byte_phase)
      2'd0:    merged = partial_bytes | {16'd0, data_byte};
      2'd1:    merged = partial_bytes | {8'd0, data_byte, 8'd0};
      2'd2:    merged = partial_bytes | {data_byte, 16'd0};
      default: merged = partial_bytes;
    endcase
  end

  always_comb begin
    emit               = 1'b0;
    bad                = 1'b0;
    color              = 24'd0;
    alpha              = 8'd0;
    byte_phase_next    = byte_phase;
    partial_bytes_next = partial_bytes;
    if (step && opcode == OP_DATA_BYTE && !frame_done) begin
      unique case (cfg.pixel_mode)
        MODE_GREY: begin
          emit  = 1'b1;
          color = {data_byte, data_byte, data_byte};
          alpha = OPAQUE;
        end
        MODE_PALETTE: begin
          emit = 1'b1;
          if (!cfg.palette_is_24bit) begin
            bad = 1'b1;
          end else begin
            color = lut_color;
            alpha = OPAQUE;
          end
        end
        MODE_BGR, MODE_BGRA: begin
          if ((cfg.pixel_mode == MODE_BGR && byte_phase == 2'd2) ||
              (cfg.pixel_mode == MODE_BGRA && byte_phase == 2'd3)) begin
            emit               = 1'b1;
            color              = merged;
            alpha              = (cfg.pixel_mode == MODE_BGRA) ? data_byte : OPAQUE;
            byte_phase_next    = 2'd0;
            partial_bytes_next = 24'd0;
          end else begin
            byte_phase_next    = byte_phase + 2'd1;
            partial_bytes_next = merged;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign last = row_end && col_end && !bad;

  always_comb begin
    column_next     = column;
    row_next        = row;
    row_base_next   = row_base;
    frame_done_next = frame_done;
    if (emit) begin
      priority if (bad || last) begin
        frame_done_next = 1'b1;
      end else if (!row_end) begin
        column_next = from_right ? column - 16'd1 : column + 16'd1;
      end else begin
        column_next = from_right ? w - 16'd1 : 16'd0;
        if (from_top) begin
          row_next      = row + 16'd1;
          row_base_next = row_base + {16'd0, w};
        end else begin
          row_next      = row - 16'd1;
          row_base_next = row_base - {16'd0, w};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= 16'd0;
      row           <= 16'd0;
      row_base      <= 32'd0;
      byte_phase    <= 2'd0;
      partial_bytes <= 24'd0;
      frame_done    <= 1'b0;
    end else if (restart) begin
      column        <= from_right ? w - 16'd1 : 16'd0;
      row           <= from_top ? 16'd0 : h - 16'd1;
      row_base      <= from_top ? 32'd0 : start_base;
      byte_phase    <= 2'd0;
      partial_bytes <= 24'd0;
      frame_done    <= 1'b0;
    end else begin
      column        <= column_next;
      row           <= row_next;
      row_base      <= row_base_next;
      byte_phase    <= byte_phase_next;
      partial_bytes <= partial_bytes_next;
      frame_done    <= frame_done_next;
    end
  end

  assign pixel.pixel_index = row_base + {16'd0, column};
  assign pixel.red         = color[23:16];
  assign pixel.green       = color[15:8];
  assign pixel.blue        = color[7:0];
  assign pixel.alpha       = alpha;
  assign pixel.last_pixel  = last;
  assign pixel.bad_palette = bad;

endmodule

// ===== src/tga_pixel_to_rgba_unit.sv =====
// Uncompressed TGA pixel decoder. Each input word is either a palette entry write
// (tuser 0) or one raw image byte (tuser 1); finished pixels leave as RGBA with their
// linear index in a top-down, left-to-right frame, tlast on the final pixel and tuser
// set on a palette error. One word is taken every clock cycle unless the output stalls
// or a restart is under way; a pixel passes the input register with the palette read,
// then the pixel step into the output register. Any write to a known configuration
// register restarts the frame, and the cycle after it rebuilds the start position
// (one row-times-width multiply), during which no image byte is processed. The palette
// is kept across restarts and must be written before it is looked up.
module tga_pixel_to_rgba_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // palette_index, palette_color, data_byte
  input  logic [tgap_pkg::IN_DATA_W-1:0]      s_tdata,
  // opcode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_index, red, green, blue, alpha
  output logic [tgap_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  // bad_palette
  output logic                                m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgap_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tgap_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import tgap_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  logic        accept;
  logic        out_free;
  logic        step;
  opcode_t     in_opcode;
  logic [7:0]  in_index;
  logic [23:0] in_color;
  logic [7:0]  in_byte;
  logic        wr_in_range;
  logic        rd_in_range;

  logic        s1_valid;
  opcode_t     s1_opcode;
  logic [7:0]  s1_byte;
  logic        s1_in_range;
  logic [23:0] rd_data;
  logic [23:0] lut_color;

  cfg_t        cfg;
  logic        restart;

  logic        emit;
  pixel_t      pixel;
  pixel_t      out_pixel;

  assign in_opcode   = opcode_t'(s_tuser);
  assign in_index    = s_tdata[7:0];
  assign in_color    = s_tdata[31:8];
  assign in_byte     = s_tdata[39:32];
  assign wr_in_range = {1'b0, in_index} < 9'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, in_byte} < 9'(PALETTE_ENTRIES);

  assign out_free = !m_tvalid || m_tready;
  assign step     = s1_valid && out_free && !restart;
  assign s_tready = !s1_valid || step;
  assign accept   = s_tvalid && s_tready;

  tgap_palette_ram #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (accept && in_opcode == OP_PALETTE_WRITE && wr_in_range),
    .wr_addr (in_index[PAL_AW-1:0]),
    .wr_data (in_color),
    .rd_en   (accept),
    .rd_addr (in_byte[PAL_AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode   <= in_opcode;
      s1_byte     <= in_byte;
      s1_in_range <= rd_in_range;
    end
  end

  assign lut_color = s1_in_range ? rd_data : 24'd0;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= 16'd1;
      cfg.frame_height     <= 16'd1;
      cfg.origin_corner    <= 2'd0;
      cfg.pixel_mode       <= MODE_GREY;
      cfg.palette_is_24bit <= 1'b1;
      restart              <= 1'b1;
    end else begin
      restart <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH: begin
            cfg.frame_width <= cfg_data[15:0];
            restart         <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            cfg.frame_height <= cfg_data[15:0];
            restart          <= 1'b1;
          end
          REG_ORIGIN_CORNER: begin
            cfg.origin_corner <= cfg_data[1:0];
            restart           <= 1'b1;
          end
          REG_PIXEL_MODE: begin
            cfg.pixel_mode <= pixel_mode_t'(cfg_data[1:0]);
            restart        <= 1'b1;
          end
          REG_PALETTE_IS_24BIT: begin
            cfg.palette_is_24bit <= cfg_data[0];
            restart              <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  tgap_pixel_step u_step (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .step      (step),
    .cfg       (cfg),
    .opcode    (s1_opcode),
    .data_byte (s1_byte),
    .lut_color (lut_color),
    .emit      (emit),
    .pixel     (pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel <= pixel;
    end
  end

  assign m_tdata = {out_pixel.alpha, out_pixel.blue, out_pixel.green, out_pixel.red,
                    out_pixel.pixel_index};
  assign m_tlast = out_pixel.last_pixel;
  assign m_tuser = out_pixel.bad_palette;

endmodule

// ===== src/tgap_checker.sv =====
`include "tga_pixel_to_rgba_unit_macros.svh"

module tgap_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tgap_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic                            m_tuser
);

  import tgap_pkg::*;

  // hold a stalled word
  `TGAP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
    "stalled output word changed")

  // the final pixel closes the frame
  `TGAP_ASSERT_NEXT(a_last_closes, m_tvalid && m_tready && m_tlast, !m_tvalid,
    "pixel emitted right after the final pixel")

  `TGAP_ASSERT_NOW(a_bad_not_last, m_tvalid && m_tuser, !m_tlast,
    "palette error marked as final pixel")

  `TGAP_ASSERT_NOW(a_bad_black, m_tvalid && m_tuser, m_tdata[63:32] == 32'd0,
    "palette error with non-zero colour")

endmodule

bind tga_pixel_to_rgba_unit tgap_checker u_tgap_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== sim/tga_pixel_to_rgba_unit_tb.sv =====
`timescale 1ns / 100ps

module tga_pixel_to_rgba_unit_tb;
  import tgap_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int WORD_TARGET = 1250;

  typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    opcode_t                op;
    logic [7:0]             pal_idx;
    logic [23:0]            colour;
    logic [7:0]             data;
    bit                     typed;
    pixel_t                 want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  tga_pixel_to_rgba_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder state as the block should hold it
  cfg_t        regs = '{16'd1, 16'd1, 2'd0, MODE_GREY, 1'b1};
  logic [15:0] cur_col;
  logic [15:0] cur_row;
  logic [31:0] cur_base;
  logic [1:0]  byte_count;
  logic [23:0] gathered_bgr;
  logic [23:0] colour_map [256];
  bit          frame_over;

  bit          entry_set [256];
  logic [7:0]  set_entries [$];
  pixel_t      pending_pixels [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          idle_pct = 15;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] eff_width();
    return (regs.frame_width == 16'd0) ? 16'd1 : regs.frame_width;
  endfunction

  function automatic logic [15:0] eff_height();
    return (regs.frame_height == 16'd0) ? 16'd1 : regs.frame_height;
  endfunction

  function automatic void restart_frame();
    cur_col = regs.origin_corner[0] ? eff_width() - 16'd1 : 16'd0;
    cur_row = regs.origin_corner[1] ? 16'd0 : eff_height() - 16'd1;
    cur_base = 32'(cur_row) * 32'(eff_width());
    byte_count = 2'd0;
    gathered_bgr = 24'd0;
    frame_over = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    bit known;
    known = 1'b1;
    case (idx)
      REG_FRAME_WIDTH:      regs.frame_width = val;
      REG_FRAME_HEIGHT:     regs.frame_height = val;
      REG_ORIGIN_CORNER:    regs.origin_corner = val[1:0];
      REG_PIXEL_MODE:       regs.pixel_mode = pixel_mode_t'(val[1:0]);
      REG_PALETTE_IS_24BIT: regs.palette_is_24bit = val[0];
      default:              known = 1'b0;
    endcase
    if (known) restart_frame();
  endfunction

  function automatic pixel_t place_pixel(input logic [7:0] r, g, b, a, input bit bad);
    logic [15:0] w;
    bit row_end;
    bit col_end;
    pixel_t p;
    w = eff_width();
    row_end = regs.origin_corner[0] ? (cur_col == 16'd0) : (cur_col == w - 16'd1);
    col_end = regs.origin_corner[1] ? (cur_row == eff_height() - 16'd1) : (cur_row == 16'd0);
    p.pixel_index = cur_base + 32'(cur_col);
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.last_pixel = row_end && col_end && !bad;
    p.bad_palette = bad;
    if (bad || p.last_pixel) begin
      frame_over = 1'b1;
    end else if (!row_end) begin
      cur_col = regs.origin_corner[0] ? cur_col - 16'd1 : cur_col + 16'd1;
    end else begin
      cur_col = regs.origin_corner[0] ? w - 16'd1 : 16'd0;
      if (regs.origin_corner[1]) begin
        cur_row = cur_row + 16'd1;
        cur_base = cur_base + 32'(w);
      end else begin
        cur_row = cur_row - 16'd1;
        cur_base = cur_base - 32'(w);
      end
    end
    return p;
  endfunction

  function automatic bit decode_word(input opcode_t op, input logic [7:0] pidx,
                                     input logic [23:0] colour, input logic [7:0] data,
                                     output pixel_t px);
    logic [23:0] c;
    px = '0;
    if (op == OP_PALETTE_WRITE) begin
      colour_map[pidx] = colour;
      return 1'b0;
    end
    if (frame_over) return 1'b0;
    case (regs.pixel_mode)
      MODE_GREY: px = place_pixel(data, data, data, OPAQUE, 1'b0);
      MODE_PALETTE: begin
        if (!regs.palette_is_24bit) begin
          px = place_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        end else begin
          c = colour_map[data];
          px = place_pixel(c[23:16], c[15:8], c[7:0], OPAQUE, 1'b0);
        end
      end
      default: begin
        if (byte_count < 2'd3) gathered_bgr[8*byte_count +: 8] = data;
        if ((regs.pixel_mode == MODE_BGR && byte_count == 2'd2) ||
            (regs.pixel_mode == MODE_BGRA && byte_count == 2'd3)) begin
          c = gathered_bgr;
          byte_count = 2'd0;
          gathered_bgr = 24'd0;
          px = place_pixel(c[23:16], c[15:8], c[7:0],
                           (regs.pixel_mode == MODE_BGRA) ? data : OPAQUE, 1'b0);
        end else begin
          byte_count = byte_count + 2'd1;
          return 1'b0;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic pixel_t mk_pixel(input logic [31:0] idx, input logic [7:0] r, g, b, a,
                                      input bit last, input bit bad);
    return {idx, r, g, b, a, last, bad};
  endfunction

  function automatic void add_reg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.op = OP_DATA_BYTE;
    r.pal_idx = 8'd0;
    r.colour = 24'd0;
    r.data = 8'd0;
    r.typed = 1'b0;
    r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void add_word(input opcode_t op, input logic [7:0] pidx,
                                   input logic [23:0] colour, input logic [7:0] data,
                                   input bit typed = 1'b0, input pixel_t want = '0);
    script_row_t r;
    r.kind = ROW_WORD;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.op = op;
    r.pal_idx = pidx;
    r.colour = colour;
    r.data = data;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic send_word(input opcode_t op, input logic [7:0] pidx,
                           input logic [23:0] colour, input logic [7:0] data,
                           input bit typed, input pixel_t want);
    pixel_t px;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {data, colour, pidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_PALETTE_WRITE || !frame_over) words_sent++;
    if (op == OP_PALETTE_WRITE && !entry_set[pidx]) begin
      entry_set[pidx] = 1'b1;
      set_entries.push_back(pidx);
    end
    if (decode_word(op, pidx, colour, data, px))
      pending_pixels.push_back(typed ? want : px);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t got;
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[39:32], m_tdata[47:40], m_tdata[55:48],
             m_tdata[63:56], m_tlast, m_tuser};
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel_index", got.pixel_index, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", got.pixel_index, want.pixel_index);
        if (got.red !== want.red)
          report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
          report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
          report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.alpha !== want.alpha)
          report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
        if (got.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
        if (got.bad_palette !== want.bad_palette)
          report_mismatch("bad_palette", 32'(got.bad_palette), 32'(want.bad_palette));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL tga_pixel_to_rgba_unit");
      $finish;
    end
  end

  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  initial begin : source
    logic [15:0]            fw;
    logic [15:0]            fh;
    logic [1:0]             corner;
    logic [1:0]             mode;
    logic                   pal24;
    logic [CFG_INDEX_W-1:0] spare_idx;
    logic [7:0]             data;
    longint                 pixels;
    int                     bpp;
    int                     n_bytes;
    int                     phase_no;

    restart_frame();

    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h00, 1'b1,
             mk_pixel(32'd0, 8'h00, 8'h00, 8'h00, OPAQUE, 1'b1, 1'b0));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'ha5);
    add_reg(REG_FRAME_WIDTH, 16'd0);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'hff, 1'b1,
             mk_pixel(32'd0, 8'hff, 8'hff, 8'hff, OPAQUE, 1'b1, 1'b0));
    add_reg(REG_FRAME_WIDTH, 16'hffff);
    add_reg(REG_FRAME_HEIGHT, 16'hffff);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h5a, 1'b1,
             mk_pixel(32'd65534 * 32'd65535, 8'h5a, 8'h5a, 8'h5a, OPAQUE, 1'b0, 1'b0));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'hc3);
    add_reg(REG_ORIGIN_CORNER, 16'd3);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h01, 1'b1,
             mk_pixel(32'd65534, 8'h01, 8'h01, 8'h01, OPAQUE, 1'b0, 1'b0));
    add_reg(REG_ORIGIN_CORNER, 16'd1);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h80, 1'b1,
             mk_pixel(32'd65535 * 32'd65535 - 32'd1, 8'h80, 8'h80, 8'h80, OPAQUE,
                      1'b0, 1'b0));
    add_reg(REG_FRAME_WIDTH, 16'd2);
    add_reg(REG_FRAME_HEIGHT, 16'd1);
    add_reg(REG_ORIGIN_CORNER, 16'd2);
    add_reg(REG_PIXEL_MODE, 16'(MODE_PALETTE));
    add_word(OP_PALETTE_WRITE, 8'h00, 24'h000000, 8'h00);
    add_word(OP_PALETTE_WRITE, 8'hff, 24'hffffff, 8'hff);
    add_word(OP_PALETTE_WRITE, 8'h12, 24'h123456, 8'h00);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'hff, 1'b1,
             mk_pixel(32'd0, 8'hff, 8'hff, 8'hff, OPAQUE, 1'b0, 1'b0));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h12, 1'b1,
             mk_pixel(32'd1, 8'h12, 8'h34, 8'h56, OPAQUE, 1'b1, 1'b0));
    add_reg(REG_ORIGIN_CORNER, 16'd0);
    add_word(OP_PALETTE_WRITE, 8'h07, 24'habcdef, 8'h00);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h07);
    add_reg(REG_PALETTE_IS_24BIT, 16'd0);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h00, 1'b1,
             mk_pixel(32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'hff);
    add_reg(REG_PALETTE_IS_24BIT, 16'd1);
    add_reg(REG_PIXEL_MODE, 16'(MODE_BGR));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h11);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h22);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h33, 1'b1,
             mk_pixel(32'd0, 8'h33, 8'h22, 8'h11, OPAQUE, 1'b0, 1'b0));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h44);
    add_reg(CFG_INDEX_W'(REG_PALETTE_IS_24BIT + 1), 16'hffff);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h55);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h66);
    add_reg(REG_PIXEL_MODE, 16'(MODE_BGRA));
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h01);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h02);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h03);
    add_word(OP_DATA_BYTE, 8'd0, 24'd0, 8'h04, 1'b1,
             mk_pixel(32'd0, 8'h03, 8'h02, 8'h01, 8'h04, 1'b0, 1'b0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG)
        write_reg(script[i].reg_idx, script[i].reg_val);
      else
        send_word(script[i].op, script[i].pal_idx, script[i].colour, script[i].data,
                  script[i].typed, script[i].want);
    end

    phase_no = 0;
    while (words_sent < WORD_TARGET) begin
      phase_no++;
      idle_pct = (phase_no >= 8 && phase_no < 14) ? 0 : 15;
      corner = 2'($urandom_range(0, 3));
      if (phase_no == 4) begin
        fw = 16'd16;
        fh = 16'd16;
        mode = MODE_GREY;
      end else begin
        fw = pick_dim();
        fh = pick_dim();
        mode = 2'($urandom_range(0, 3));
      end
      pal24 = ($urandom_range(0, 7) != 0);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_ORIGIN_CORNER, {14'($urandom), corner});
      write_reg(REG_PIXEL_MODE, {14'($urandom), mode});
      write_reg(REG_PALETTE_IS_24BIT, {15'($urandom), pal24});
      if ($urandom_range(0, 3) == 0) begin
        spare_idx = CFG_INDEX_W'($urandom_range(32'(REG_PALETTE_IS_24BIT) + 1,
                                                2**CFG_INDEX_W - 1));
        write_reg(spare_idx, 16'($urandom));
      end

      bpp = (mode == MODE_BGR) ? 3 : (mode == MODE_BGRA) ? 4 : 1;
      pixels = longint'(fw == 16'd0 ? 16'd1 : fw) * longint'(fh == 16'd0 ? 16'd1 : fh);
      if (phase_no == 4 || (pixels <= 64 && $urandom_range(0, 4) != 0))
        n_bytes = int'(pixels) * bpp + $urandom_range(0, 3);
      else
        n_bytes = $urandom_range(1, 40);
      if (phase_no == 4) hold_request = 1'b1;

      for (int i = 0; i < n_bytes; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_word(OP_PALETTE_WRITE, 8'($urandom), 24'($urandom), 8'($urandom), 1'b0, '0);
        if (regs.pixel_mode == MODE_PALETTE)
          data = set_entries[$urandom_range(0, set_entries.size() - 1)];
        else
          data = 8'($urandom);
        send_word(OP_DATA_BYTE, 8'($urandom), 24'($urandom), data, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS tga_pixel_to_rgba_unit");
    else
      $display("FAIL tga_pixel_to_rgba_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/tgap_pkg.sv
src/tgap_palette_ram.sv
src/tgap_pixel_step.sv
src/tga_pixel_to_rgba_unit.sv
src/tgap_checker.sv
sim/tga_pixel_to_rgba_unit_tb.sv
